// ----- sv/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII converter
// Holds the sequencer states, the input codes, the character constants and
// the status bundle of the iterative BCD unit.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

	// Default operand width cap.
	localparam int MAX_VALUE_BITS_DEF = 64;

	// Width class codes; any other code selects the widest class.
	localparam logic [1:0] WCLASS_16 = 2'd0;
	localparam logic [1:0] WCLASS_32 = 2'd1;

	// Base selector codes; any other code selects hexadecimal.
	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;

	// ASCII constants.
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_NINE  = 7'h39;
	localparam logic [6:0] CHAR_LC_A  = 7'h61;
	localparam logic [6:0] CHAR_LC_F  = 7'h66;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Status of the iterative binary to BCD unit.
	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

	// Map one digit value to its lower case ASCII character.
	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_LC_A + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/integer_to_ascii_radix_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core: integer to ASCII text in base 8, 10 or 16
// Converts one integer word into a stream of character words, most
// significant first, with the final character marked by last.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one word: value, width_class,
// signed_mode and base_select. The output channel (out_valid/out_ready) sends
// one character word per cycle while out_ready is high, once leading zeros are
// skipped: an optional '-', then the digits without leading zeros, lower case
// hex; zero gives a single '0'. last marks the final character of each number.
// in_ready is high only while the block is idle; one word is converted at a
// time. After acceptance ST_PREP sets the scan position and, for octal and
// hex, fills the digit buffer; decimal fills it from the shift-and-add-3 BCD
// unit, one operand bit per cycle. Emission then scans from the top digit slot
// of the chosen base, skipping leading zeros one slot at a time, and sends the
// characters.
// When the receiver stalls, the current character holds and the block waits.
// Reset returns the sequencer to idle; no stored data needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_core
	import itoa_pkg::*;
#(
	parameter int MAX_VALUE_BITS = MAX_VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [63:0] value,
	input  wire logic [1:0]  width_class,
	input  wire logic        signed_mode,
	input  wire logic [1:0]  base_select,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [6:0]  ascii_char,
	output      logic        last
);

	localparam int MAXB     = MAX_VALUE_BITS;
	localparam int W32      = (MAXB < 32) ? MAXB : 32;
	localparam int NDIG_OCT = (MAXB + 2) / 3;
	localparam int NDIG_HEX = (MAXB + 3) / 4;
	localparam int NDIG_DEC = ((MAXB * 1233) >> 12) + 1;
	localparam int NDIG     = NDIG_OCT;
	localparam int IDX_W    = $clog2(NDIG);
	localparam int PADW     = (NDIG_OCT * 3 > NDIG_HEX * 4) ? NDIG_OCT * 3 : NDIG_HEX * 4;

	state_t state_q, state_d;

	logic [MAXB-1:0]       mask;
	logic [MAXB-1:0]       bits;
	logic                  sign_bit;
	logic                  neg;
	logic [MAXB-1:0]       mag;
	logic [MAXB-1:0]       mag_q;
	logic                  neg_q;
	logic [1:0]            base_q;
	logic [3:0]            dig_q [NDIG];
	logic [IDX_W-1:0]      idx_q;
	logic                  seen_q;
	logic [PADW-1:0]       mag_pad;
	logic [3:0]            cur;
	logic                  skip;
	logic                  bcd_start;
	bcd_stat_t             bcd_stat;
	logic [NDIG_DEC*4-1:0] bcd;

	// Width selection, sign detection and exact magnitude.
	always_comb begin
		case (width_class)
			WCLASS_16: begin
				mask     = MAXB'(16'hFFFF);
				sign_bit = value[15];
			end
			WCLASS_32: begin
				mask     = MAXB'({W32{1'b1}});
				sign_bit = value[W32-1];
			end
			default: begin
				mask     = '1;
				sign_bit = value[MAXB-1];
			end
		endcase
		bits = value[MAXB-1:0] & mask;
		neg  = signed_mode & sign_bit;
		mag  = neg ? ((~bits + 1'b1) & mask) : bits;
	end

	assign mag_pad = PADW'(mag_q);

	// The BCD unit is shared by every decimal word.
	itoa_bcd_unit #(
		.BITS   (MAXB),
		.DIGITS (NDIG_DEC)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (mag_q),
		.stat   (bcd_stat),
		.bcd    (bcd)
	);

	// Digit at the scan position; leading zeros are skipped silently.
	assign cur  = dig_q[idx_q];
	assign skip = (state_q == ST_EMIT) && !seen_q && (cur == 4'd0) && (idx_q != '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (base_q == BASE_DEC) begin
					state_d = ST_CONV;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_CONV: begin
				if (bcd_stat.done) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_ready) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!skip && out_ready && (idx_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake and character outputs.
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		out_valid  = (state_q == ST_SIGN) || ((state_q == ST_EMIT) && !skip);
		last       = (state_q == ST_EMIT) && (idx_q == '0);
		ascii_char = (state_q == ST_SIGN) ? CHAR_MINUS : digit_char(cur);
		bcd_start  = (state_q == ST_PREP) && (base_q == BASE_DEC);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Word capture, digit buffer fill and scan position.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mag_q  <= mag;
			neg_q  <= neg;
			base_q <= base_select;
		end
		if (state_q == ST_PREP) begin
			seen_q <= 1'b0;
			if (base_q == BASE_OCT) begin
				idx_q <= IDX_W'(NDIG_OCT - 1);
				for (int i = 0; i < NDIG; i++) begin
					dig_q[i] <= {1'b0, mag_pad[3*i +: 3]};
				end
			end else if (base_q == BASE_DEC) begin
				idx_q <= IDX_W'(NDIG_DEC - 1);
			end else begin
				idx_q <= IDX_W'(NDIG_HEX - 1);
				for (int i = 0; i < NDIG_HEX; i++) begin
					dig_q[i] <= mag_pad[4*i +: 4];
				end
				for (int i = NDIG_HEX; i < NDIG; i++) begin
					dig_q[i] <= 4'd0;
				end
			end
		end
		if ((state_q == ST_CONV) && bcd_stat.done) begin
			for (int i = 0; i < NDIG_DEC; i++) begin
				dig_q[i] <= bcd[4*i +: 4];
			end
			for (int i = NDIG_DEC; i < NDIG; i++) begin
				dig_q[i] <= 4'd0;
			end
		end
		if (state_q == ST_EMIT) begin
			if (skip) begin
				idx_q <= idx_q - 1'b1;
			end else if (out_ready) begin
				seen_q <= 1'b1;
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/itoa_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// itoa_bcd_unit: iterative binary to BCD converter
// Shift-and-add-3 conversion, one operand bit per cycle. All BCD digits are
// adjusted in parallel each cycle, then the whole register shifts left.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_bcd_unit
	import itoa_pkg::*;
#(
	parameter int BITS   = MAX_VALUE_BITS_DEF,
	parameter int DIGITS = ((BITS * 1233) >> 12) + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [BITS-1:0]       bin,
	output      bcd_stat_t             stat,
	output      logic [DIGITS*4-1:0]   bcd
);

	localparam int CNT_W = $clog2(BITS + 1);

	logic [BITS-1:0]     bin_q;
	logic [DIGITS*4-1:0] bcd_q;
	logic [DIGITS*4-1:0] adj;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	// Add 3 to every digit that is 5 or more before the shift.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Control: bit counter, busy and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q  <= CNT_W'(BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand and BCD shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[DIGITS*4-2:0], bin_q[BITS-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

`default_nettype wire

// ----- sv/itoa_checker.sv -----
// ----------------------------------------------------------------------------
// itoa_checker: port-level checks for integer_to_ascii_radix_core
// Watches the two channels and the character stream, and is bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_checker
	import itoa_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] ascii_char,
	input wire logic       last
);

	// A stalled character word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(ascii_char) && $stable(last))
		else $error("stalled output word changed");

	// The block never takes a new word while characters are pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while output word pending");

	// Only a minus sign, decimal digits or lower case hex digits leave.
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ascii_char == CHAR_MINUS) ||
			((ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_NINE)) ||
			((ascii_char >= CHAR_LC_A) && (ascii_char <= CHAR_LC_F)))
		else $error("illegal output character");

	// The minus sign is never the last character of a number.
	a_minus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ascii_char == CHAR_MINUS) |-> !last)
		else $error("minus sign marked last");

endmodule

bind integer_to_ascii_radix_core itoa_checker u_itoa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ascii_char (ascii_char),
	.last       (last)
);

`default_nettype wire

// ----- dv/integer_to_ascii_radix_checker.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_checker: text predictor and scoreboard
// Watches both channels of the converter. Every accepted number word is
// turned into its expected character words; every accepted character word is
// compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_checker
	import itoa_pkg::*;
#(
	parameter int MAX_VALUE_BITS = MAX_VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] value,
	input  wire logic [1:0]  width_class,
	input  wire logic        signed_mode,
	input  wire logic [1:0]  base_select,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [6:0]  ascii_char,
	input  wire logic        last,
	output int               fail_count,
	output int               expected_left,
	output int               chars_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	// One expected character word.
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} char_word_t;

	char_word_t expected_text[$];

	// Build the text of one number and append it to the expected words.
	task automatic predict_text(input logic [63:0] raw, input logic [1:0] wcls,
			input logic sgn, input logic [1:0] bsel);
		int unsigned nbits;
		logic [63:0] mask;
		logic [63:0] bits;
		logic [63:0] mag;
		logic [63:0] radix;
		logic [3:0]  digit;
		logic        neg;
		logic [6:0]  digits[$];
		char_word_t  w;

		// Operand width, capped by the build parameter.
		if (wcls == WCLASS_16)
			nbits = 16;
		else if (wcls == WCLASS_32)
			nbits = 32;
		else
			nbits = 64;
		if (nbits > MAX_VALUE_BITS)
			nbits = MAX_VALUE_BITS;
		mask = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 64'd1);
		bits = raw & mask;

		if (bsel == BASE_OCT)
			radix = 64'd8;
		else if (bsel == BASE_DEC)
			radix = 64'd10;
		else
			radix = 64'd16;

		// Sign and magnitude; the most negative value keeps its full magnitude.
		neg = sgn && bits[nbits-1];
		mag = neg ? ((~bits + 64'd1) & mask) : bits;

		// Digits come out least significant first.
		do begin
			digit = 4'(mag % radix);
			mag = mag / radix;
			if (digit < 4'd10)
				digits.push_front(CHAR_ZERO + 7'(digit));
			else
				digits.push_front(CHAR_LC_A + 7'(digit - 4'd10));
		end while (mag != 64'd0);

		if (neg) begin
			w.ch = CHAR_MINUS;
			w.last = 1'b0;
			expected_text.push_back(w);
		end
		for (int i = 0; i < digits.size(); i++) begin
			w.ch = digits[i];
			w.last = (i == digits.size() - 1);
			expected_text.push_back(w);
		end
	endtask

	// Sample both channels at the clock edge and keep the scoreboard.
	always @(posedge clk) begin : scoreboard
		char_word_t exp_w;
		if (!arst_n) begin
			fail_count    <= 0;
			expected_left <= 0;
			chars_seen    <= 0;
			expected_text.delete();
		end else begin
			if (in_valid && in_ready)
				predict_text(value, width_class, signed_mode, base_select);
			if (out_valid && out_ready) begin
				chars_seen <= chars_seen + 1;
				if (expected_text.size() == 0) begin
					$error("unexpected character word: ascii_char %02h last %0b",
						ascii_char, last);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_text.pop_front();
					if (ascii_char !== exp_w.ch || last !== exp_w.last)
						fail_count <= fail_count + 1;
					if (ascii_char !== exp_w.ch)
						$error("ascii_char mismatch: expected %02h, actual %02h",
							exp_w.ch, ascii_char);
					if (last !== exp_w.last)
						$error("last mismatch: expected %0b, actual %0b",
							exp_w.last, last);
				end
			end
			expected_left <= expected_text.size();
		end
	end

endmodule

`default_nettype wire

// ----- dv/integer_to_ascii_radix_core_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core_tb: testbench top for the integer converter
// Sends directed edge numbers and then random numbers in bursts, stalls the
// character side on a pattern of its own, and reports the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_core_tb;
	import itoa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_CAP      = MAX_VALUE_BITS_DEF;
	localparam int RANDOM_NUMBERS = 300;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 120;

	localparam logic [1:0] WCLASS_64  = 2'd2;
	localparam logic [1:0] WCLASS_ALT = 2'd3;
	localparam logic [1:0] BASE_HEX   = 2'd2;
	localparam logic [1:0] BASE_ALT   = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] value = '0;
	logic [1:0]  width_class = '0;
	logic        signed_mode = 1'b0;
	logic [1:0]  base_select = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  ascii_char;
	logic        last;

	int fail_count;
	int expected_left;
	int chars_seen;
	int numbers_sent = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_stall_run = 0;

	always #10 clk = ~clk;

	integer_to_ascii_radix_core #(
		.MAX_VALUE_BITS(VALUE_CAP)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.width_class(width_class),
		.signed_mode(signed_mode),
		.base_select(base_select),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char),
		.last       (last)
	);

	integer_to_ascii_radix_checker #(
		.MAX_VALUE_BITS(VALUE_CAP)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.width_class  (width_class),
		.signed_mode  (signed_mode),
		.base_select  (base_select),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ascii_char   (ascii_char),
		.last         (last),
		.fail_count   (fail_count),
		.expected_left(expected_left),
		.chars_seen   (chars_seen)
	);

	// Character side: phases of always ready, light stalls and heavy stalls.
	always @(posedge clk) begin : rx_pattern
		logic stall;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(8, 64);
		end
		rx_left--;
		case (rx_mode)
			0: stall = 1'b0;
			1: stall = ($urandom_range(0, 3) == 0);
			default: stall = ($urandom_range(0, 9) < 6);
		endcase
		if (rx_stall_run >= 6)
			stall = 1'b0;
		rx_stall_run = stall ? rx_stall_run + 1 : 0;
		out_ready <= !stall;
	end

	// Watchdog: ends the run when no word moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one number word and hold it until it is taken.
	task automatic send_number(input logic [63:0] v, input logic [1:0] w,
			input logic s, input logic [1:0] b);
		in_valid <= 1'b1;
		value <= v;
		width_class <= w;
		signed_mode <= s;
		base_select <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		numbers_sent++;
	endtask

	// Drop valid and wait until every expected character has come out.
	task automatic drain_text();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
	endtask

	// Random operand bits, weighted toward the interesting boundaries.
	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		int sh;
		sh = $urandom_range(0, 63);
		case ($urandom_range(0, 6))
			0: v = {$urandom, $urandom};
			1: v = 64'($urandom_range(0, 40));
			2: v = 64'd1 << sh;
			3: v = (64'd1 << sh) - 64'd1;
			4: v = (64'd1 << sh) + 64'($urandom_range(0, 3));
			5: v = -64'($urandom_range(1, 40));
			default: v = {$urandom, $urandom} >> sh;
		endcase
		return v;
	endfunction

	initial begin : stimulus
		int burst_left;
		int gap;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero in each base, width extremes, most negative values,
		// and the width class and base codes that alias to the widest class and hex.
		send_number(64'd0, WCLASS_16, 1'b0, BASE_OCT);
		send_number(64'd0, WCLASS_32, 1'b1, BASE_DEC);
		send_number(64'd0, WCLASS_64, 1'b0, BASE_HEX);
		send_number(64'h0000_0000_0000_ffff, WCLASS_16, 1'b0, BASE_DEC);
		send_number(64'h0000_0000_0000_8000, WCLASS_16, 1'b1, BASE_DEC);
		send_number(64'h0000_0000_0000_ffff, WCLASS_16, 1'b1, BASE_HEX);
		send_number(64'h0000_0000_0000_7fff, WCLASS_16, 1'b1, BASE_OCT);
		send_number(64'hdead_beef_1234_8765, WCLASS_16, 1'b1, BASE_HEX);
		send_number(64'h0000_0000_ffff_ffff, WCLASS_32, 1'b0, BASE_OCT);
		send_number(64'h0000_0000_8000_0000, WCLASS_32, 1'b1, BASE_DEC);
		send_number(64'hffff_ffff_7fff_ffff, WCLASS_32, 1'b1, BASE_HEX);
		send_number(64'hffff_ffff_ffff_ffff, WCLASS_64, 1'b0, BASE_DEC);
		send_number(64'hffff_ffff_ffff_ffff, WCLASS_64, 1'b1, BASE_DEC);
		send_number(64'h8000_0000_0000_0000, WCLASS_64, 1'b1, BASE_OCT);
		send_number(64'h8000_0000_0000_0000, WCLASS_64, 1'b1, BASE_DEC);
		send_number(64'h8000_0000_0000_0000, WCLASS_64, 1'b0, BASE_HEX);
		send_number(64'h7fff_ffff_ffff_ffff, WCLASS_64, 1'b1, BASE_HEX);
		send_number(64'h0123_4567_89ab_cdef, WCLASS_64, 1'b0, BASE_HEX);
		send_number(64'hfedc_ba98_7654_3210, WCLASS_ALT, 1'b1, BASE_DEC);
		send_number(64'h0000_0000_0000_abcd, WCLASS_16, 1'b0, BASE_ALT);
		send_number(64'hffff_ffff_ffff_fff7, WCLASS_ALT, 1'b1, BASE_ALT);
		send_number(64'd9, WCLASS_32, 1'b0, BASE_DEC);
		drain_text();

		// Random numbers in bursts with gaps; one full drain halfway.
		burst_left = 0;
		for (int n = 0; n < RANDOM_NUMBERS; n++) begin
			if (n == RANDOM_NUMBERS / 2)
				drain_text();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = (n > 200 && n < 240) ? 0 : $urandom_range(0, 8);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			send_number(pick_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)));
		end

		drain_text();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d numbers into %0d checked characters,", numbers_sent,
			chars_seen);
		$display("over all width classes, signed and unsigned, in octal, decimal and hex.");
		if (fail_count == 0 && expected_left == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
